@@ src/wss_pkg.sv @@
// Shared types, constants and state encoding for the windowed sample statistics block.
`default_nettype none

package wss_pkg;

  // Default sizing of the statistics engine
  localparam int NUM_TYPES_DEF    = 64;
  localparam int LONG_WINDOW_DEF  = 300;
  localparam int SHORT_WINDOW_DEF = 60;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // One incoming sample
  typedef struct packed {
    logic        [7:0]  data_type;
    logic signed [31:0] sample_value;
    logic signed [31:0] collect_time;
  } wss_in_t;

  // One result transaction
  typedef struct packed {
    logic               type_error;
    logic               report;
    logic        [7:0]  type_echo;
    logic signed [31:0] time_echo;
    logic signed [31:0] mean_short;
    logic signed [31:0] mean_long;
    logic signed [31:0] min_short;
    logic signed [31:0] min_long;
    logic signed [31:0] max_short;
    logic signed [31:0] max_long;
  } wss_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POS,
    ST_SCAN,
    ST_DRAIN,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } wss_state_t;

endpackage

`default_nettype wire

@@ src/wss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/wss_div.sv @@
// Division by a constant through a reciprocal multiply, one 16-bit slice of the reciprocal per cycle.
`default_nettype none

module wss_div #(
  parameter int W       = 40,
  parameter int DIVISOR = 60
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  output logic              done,
  output logic      [W-1:0] quotient
);

  // ceil(2^(W+SH) / DIVISOR) gives the exact floor for every W-bit dividend
  localparam int SH    = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int SLICE = 16;
  localparam int NSL   = (W + 2 + SLICE - 1) / SLICE;
  localparam int RW    = NSL * SLICE;
  localparam int PW    = 2 * W + SH + 2;
  localparam int CW    = (NSL > 1) ? $clog2(NSL) : 1;
  localparam logic [RW-1:0] RECIP =
    RW'(((longint'(1) << (W + SH)) + longint'(DIVISOR - 1)) / longint'(DIVISOR));

  logic [W-1:0]       mag_r;
  logic [RW-1:0]      rcp_r;
  logic [PW-1:0]      acc_r, acc_nxt;
  logic [W+SLICE-1:0] part;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, done_r;

  // Horner step: move the partial product up one slice, add dividend x next slice
  // (upper operand bits are zero, the multiplier is W x 16)
  always_comb begin
    part    = (W+SLICE)'(mag_r) * (W+SLICE)'(rcp_r[RW-1 -: SLICE]);
    acc_nxt = {acc_r[PW-SLICE-1:0], {SLICE{1'b0}}} + PW'(part);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NSL - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: reciprocal slices go out most significant first
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= dividend;
      rcp_r <= RECIP;
      acc_r <= '0;
    end else if (busy_r) begin
      rcp_r <= rcp_r << SLICE;
      acc_r <= acc_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = acc_r[W+SH +: W];

endmodule

`default_nettype wire

@@ src/windowed_sample_statistics.sv @@
// Top level: per-type sliding window mean, minimum and maximum over a ring store.
//
// Input channel in_valid/in_ready/in_data carries one sample per transaction;
// output channel out_valid/out_ready/out_data returns exactly one result for
// every accepted sample, in order.
// After reset the block runs a clearing pass over all NUM_TYPES*LONG_WINDOW
// entries (19200 at the defaults) that zeroes the sample store and the per-type
// write positions; in_ready stays low until it completes.
// A sample with a bad type skips the ring and position update. A sample that
// closes a short window walks the single read port of the sample RAM once per
// entry of both windows, then the two means come out of reciprocal multipliers
// that take three 16-bit slices at the defaults.
// A new sample is taken only once the previous one has finished, but the
// result register frees the input side: a finished result may wait for
// out_ready while the next sample is already being processed. If the
// receiver keeps stalling, the next result waits in the sequencer and
// in_ready stays low until the result register is free.
`default_nettype none

module windowed_sample_statistics
  import wss_pkg::*;
#(
  parameter int NUM_TYPES    = NUM_TYPES_DEF,     // 1..256
  parameter int LONG_WINDOW  = LONG_WINDOW_DEF,   // 2..1024
  parameter int SHORT_WINDOW = SHORT_WINDOW_DEF   // 1..1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire wss_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output wss_out_t      out_data
);

  localparam int DEPTH   = NUM_TYPES * LONG_WINDOW;
  localparam int AW      = $clog2(DEPTH);
  localparam int TYPE_AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int IDX_W   = $clog2(LONG_WINDOW);
  localparam int PH_W    = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
  localparam int POS_W   = IDX_W + PH_W;
  localparam int SCAN_N  = SHORT_WINDOW + LONG_WINDOW;
  localparam int CNT_W   = $clog2(SCAN_N);
  localparam int SSUM_W  = 32 + $clog2(SHORT_WINDOW + 1);
  localparam int LSUM_W  = 32 + $clog2(LONG_WINDOW + 1);

  wss_state_t state_r, state_nxt;

  // Sample latched at acceptance
  wss_in_t        in_r;
  logic           err_r;
  logic           rep_r;
  logic [AW-1:0]  base_r;
  logic [AW-1:0]  clr_cnt_r;

  // Scan control
  logic [CNT_W-1:0] scan_cnt_r;
  logic [IDX_W-1:0] s_idx_r, l_idx_r;
  logic             scan_short;
  logic             rd_v_r, rd_short_r;

  // Accumulators
  logic signed [SSUM_W-1:0] ssum_r;
  logic signed [LSUM_W-1:0] lsum_r;
  logic signed [31:0]       smin_r, smax_r, lmin_r, lmax_r;

  // Output register
  wss_out_t out_r;
  logic     out_valid_r;

  // RAM hookup
  logic             smp_we;
  logic [AW-1:0]    smp_waddr, smp_raddr;
  logic [31:0]      smp_wdata, smp_rdata;
  logic             pos_we;
  logic [TYPE_AW-1:0] pos_waddr;
  logic [POS_W-1:0] pos_wdata, pos_rdata;

  // Position update for the current sample
  logic [IDX_W-1:0] last_idx, next_idx;
  logic [PH_W-1:0]  last_ph, next_ph;
  logic             closes_short;

  // Divider hookup
  logic              div_start;
  logic              sdiv_done, ldiv_done;
  logic [SSUM_W-1:0] smag, squo;
  logic [LSUM_W-1:0] lmag, lquo;
  logic signed [31:0] smean, lmean;

  logic in_acc, out_free, clr_last, scan_last, type_bad;

  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
  assign scan_last = (scan_cnt_r == CNT_W'(SCAN_N - 1));
  assign scan_short = (scan_cnt_r < CNT_W'(SHORT_WINDOW));
  assign type_bad  = ({1'b0, in_data.data_type} >= 9'(NUM_TYPES));

  // Next write position and phase within the short window
  always_comb begin
    last_idx = pos_rdata[IDX_W-1:0];
    last_ph  = pos_rdata[POS_W-1:IDX_W];
    next_idx = (last_idx == IDX_W'(LONG_WINDOW - 1)) ? '0 : last_idx + 1'b1;
    if (next_idx == '0) begin
      next_ph = '0;
    end else if (last_ph == PH_W'(SHORT_WINDOW - 1)) begin
      next_ph = '0;
    end else begin
      next_ph = last_ph + 1'b1;
    end
    closes_short = (next_ph == '0);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) state_nxt = type_bad ? ST_DONE : ST_POS;
      end
      ST_POS:   state_nxt = closes_short ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV:   if (sdiv_done && ldiv_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    smp_we    = 1'b0;
    smp_waddr = base_r + AW'(last_idx);
    smp_wdata = in_r.sample_value;
    pos_we    = 1'b0;
    pos_waddr = in_r.data_type[TYPE_AW-1:0];
    pos_wdata = {next_ph, next_idx};
    unique case (state_r)
      ST_CLEAR: begin
        smp_we    = 1'b1;
        smp_waddr = clr_cnt_r;
        smp_wdata = '0;
        pos_we    = (clr_cnt_r < AW'(NUM_TYPES));
        pos_waddr = clr_cnt_r[TYPE_AW-1:0];
        pos_wdata = '0;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_POS: begin
        smp_we = 1'b1;
        pos_we = 1'b1;
      end
      ST_DIVGO: div_start = 1'b1;
      default: ;
    endcase
  end

  assign smp_raddr = base_r + AW'(scan_short ? s_idx_r : l_idx_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_POS) begin
        scan_cnt_r <= '0;
      end else if (state_r == ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      rd_v_r <= (state_r == ST_SCAN);
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample latch and scan indices
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r   <= in_data;
      err_r  <= type_bad;
      rep_r  <= 1'b0;
      base_r <= AW'(32'(in_data.data_type) * LONG_WINDOW);
    end
    if (state_r == ST_POS) begin
      rep_r   <= closes_short;
      s_idx_r <= last_idx;
      l_idx_r <= '0;
    end else if (state_r == ST_SCAN) begin
      if (scan_short) begin
        s_idx_r <= (s_idx_r == '0) ? IDX_W'(LONG_WINDOW - 1) : s_idx_r - 1'b1;
      end else begin
        l_idx_r <= l_idx_r + 1'b1;
      end
    end
    rd_short_r <= scan_short;
  end

  // Sum, minimum and maximum over the read stream
  always_ff @(posedge clk) begin
    if (state_r == ST_POS) begin
      ssum_r <= '0;
      lsum_r <= '0;
      smin_r <= S32_MAX;
      smax_r <= S32_MIN;
      lmin_r <= S32_MAX;
      lmax_r <= S32_MIN;
    end else if (rd_v_r) begin
      if (rd_short_r) begin
        ssum_r <= ssum_r + SSUM_W'(signed'(smp_rdata));
        if (signed'(smp_rdata) < smin_r) smin_r <= signed'(smp_rdata);
        if (signed'(smp_rdata) > smax_r) smax_r <= signed'(smp_rdata);
      end else begin
        lsum_r <= lsum_r + LSUM_W'(signed'(smp_rdata));
        if (signed'(smp_rdata) < lmin_r) lmin_r <= signed'(smp_rdata);
        if (signed'(smp_rdata) > lmax_r) lmax_r <= signed'(smp_rdata);
      end
    end
  end

  // Means: divide magnitudes, restore sign (truncation toward zero)
  assign smag  = ssum_r[SSUM_W-1] ? SSUM_W'(-ssum_r) : SSUM_W'(ssum_r);
  assign lmag  = lsum_r[LSUM_W-1] ? LSUM_W'(-lsum_r) : LSUM_W'(lsum_r);
  assign smean = ssum_r[SSUM_W-1] ? 32'(~squo + 1'b1) : 32'(squo);
  assign lmean = lsum_r[LSUM_W-1] ? 32'(~lquo + 1'b1) : 32'(lquo);

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_r.type_error <= err_r;
      out_r.report     <= rep_r;
      out_r.type_echo  <= in_r.data_type;
      out_r.time_echo  <= in_r.collect_time;
      out_r.mean_short <= rep_r ? smean  : '0;
      out_r.mean_long  <= rep_r ? lmean  : '0;
      out_r.min_short  <= rep_r ? smin_r : '0;
      out_r.min_long   <= rep_r ? lmin_r : '0;
      out_r.max_short  <= rep_r ? smax_r : '0;
      out_r.max_long   <= rep_r ? lmax_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Ring store, all types back to back
  wss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (smp_wdata),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  // Per-type write position and short-window phase
  wss_ram #(.WIDTH(POS_W), .DEPTH(NUM_TYPES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (in_data.data_type[TYPE_AW-1:0]),
    .rdata (pos_rdata)
  );

  wss_div #(.W(SSUM_W), .DIVISOR(SHORT_WINDOW)) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (smag),
    .done     (sdiv_done),
    .quotient (squo)
  );

  wss_div #(.W(LSUM_W), .DIVISOR(LONG_WINDOW)) u_ldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lmag),
    .done     (ldiv_done),
    .quotient (lquo)
  );

endmodule

`default_nettype wire

@@ src/wss_checker.sv @@
// Port-level checker for the windowed sample statistics block, bound to the top level.
`default_nettype none

module wss_assertions
  import wss_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire wss_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire wss_out_t out_data
);

  // One sample in flight: no back-to-back input transactions
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Results without a report carry no statistics
  a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.report |->
      out_data.mean_short == 0 && out_data.mean_long == 0 &&
      out_data.min_short == 0 && out_data.min_long == 0 &&
      out_data.max_short == 0 && out_data.max_long == 0)
    else $error("statistics on a result without report");

  // A bad type never reports
  a_err_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.type_error |-> !out_data.report)
    else $error("report on a type error");

  // Mean lies between minimum and maximum
  a_mean_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.report |->
      out_data.min_short <= out_data.mean_short &&
      out_data.mean_short <= out_data.max_short &&
      out_data.min_long <= out_data.mean_long &&
      out_data.mean_long <= out_data.max_long)
    else $error("mean outside min/max");

endmodule

bind windowed_sample_statistics wss_assertions u_wss_assertions (.*);

`default_nettype wire

@@ test/wss_checker.sv @@
// Watches both channels of the statistics block, predicts each result and compares it.
`timescale 1ns / 1ps

module wss_checker
  import wss_pkg::*;
#(
  parameter int NUM_TYPES    = NUM_TYPES_DEF,
  parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW = SHORT_WINDOW_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  wss_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  wss_out_t out_data,
  output int       mismatch_count,
  output int       results_pending
);

  // Shadow copy of the per-type rings and write positions
  logic signed [31:0] ring_store [NUM_TYPES][LONG_WINDOW];
  int unsigned        write_pos  [NUM_TYPES];
  wss_out_t           expected_results [$];
  int                 result_index;

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] ERROR result %0d: %s", $time, result_index, what);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s = %0h, expected %0h", field, got, want));
    end
  endtask

  // Stores the sample and, when it closes a short window, scans both windows
  function automatic wss_out_t predict_window_stats(wss_in_t smp);
    wss_out_t           res;
    int unsigned        t;
    int unsigned        last_pos;
    int unsigned        next_pos;
    int unsigned        idx;
    longint             sum_s;
    longint             sum_l;
    logic signed [31:0] v;
    logic signed [31:0] min_s;
    logic signed [31:0] max_s;
    logic signed [31:0] min_l;
    logic signed [31:0] max_l;
    res = '0;
    res.type_echo = smp.data_type;
    res.time_echo = smp.collect_time;
    t = smp.data_type;
    // bad type: flagged, nothing stored
    if (t >= NUM_TYPES) begin
      res.type_error = 1'b1;
      return res;
    end
    last_pos = write_pos[t];
    next_pos = (last_pos + 1) % LONG_WINDOW;
    ring_store[t][last_pos] = smp.sample_value;
    write_pos[t] = next_pos;
    if (next_pos % SHORT_WINDOW == 0) begin
      sum_s = 0;
      sum_l = 0;
      min_s = S32_MAX;
      max_s = S32_MIN;
      min_l = S32_MAX;
      max_l = S32_MIN;
      // newest entries, walking backward with wrap
      idx = last_pos;
      for (int k = 0; k < SHORT_WINDOW; k++) begin
        v = ring_store[t][idx];
        sum_s += v;
        if (v < min_s) min_s = v;
        if (v > max_s) max_s = v;
        idx = (idx == 0) ? LONG_WINDOW - 1 : idx - 1;
      end
      // whole ring, unwritten entries count as zero
      for (int k = 0; k < LONG_WINDOW; k++) begin
        v = ring_store[t][k];
        sum_l += v;
        if (v < min_l) min_l = v;
        if (v > max_l) max_l = v;
      end
      res.report     = 1'b1;
      res.mean_short = 32'(sum_s / longint'(SHORT_WINDOW));
      res.mean_long  = 32'(sum_l / longint'(LONG_WINDOW));
      res.min_short  = min_s;
      res.min_long   = min_l;
      res.max_short  = max_s;
      res.max_long   = max_l;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    wss_out_t want;
    if (!rst_n) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        write_pos[t] = 0;
        for (int k = 0; k < LONG_WINDOW; k++) ring_store[t][k] = '0;
      end
      expected_results.delete();
      mismatch_count = 0;
      result_index = 0;
    end else begin
      // result side first: a result never belongs to a sample taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no sample outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("type_error", out_data.type_error, want.type_error);
          check_field("report", out_data.report, want.report);
          check_field("type_echo", out_data.type_echo, want.type_echo);
          check_field("time_echo", out_data.time_echo, want.time_echo);
          check_field("mean_short", out_data.mean_short, want.mean_short);
          check_field("mean_long", out_data.mean_long, want.mean_long);
          check_field("min_short", out_data.min_short, want.min_short);
          check_field("min_long", out_data.min_long, want.min_long);
          check_field("max_short", out_data.max_short, want.max_short);
          check_field("max_long", out_data.max_long, want.max_long);
        end
        result_index++;
      end
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), predict_window_stats(in_data));
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

@@ test/testbench.sv @@
// Testbench top: clock, reset, sample stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
  import wss_pkg::*;

  localparam int RANDOM_SAMPLES = 1450;
  localparam int QUIET_FROM     = RANDOM_SAMPLES * 85 / 100;
  // a report scans both windows and runs two reciprocal divides
  localparam int REPORT_LATENCY = SHORT_WINDOW_DEF + LONG_WINDOW_DEF + 100;
  // clearing pass plus every sample taking a full report with worst stalls and gaps, x3
  localparam longint CYCLE_LIMIT =
    3 * (longint'(NUM_TYPES_DEF * LONG_WINDOW_DEF) + 1700 * (REPORT_LATENCY + 10));

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  wss_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  wss_out_t out_data;
  int       mismatch_count;
  int       results_pending;
  logic     quiet     = 1'b0;
  int       stall_left = 0;
  longint   cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  windowed_sample_statistics uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  wss_checker result_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches, none in the tail
  always @(posedge clk) begin
    if (quiet || (cycle_count / 1500) % 4 == 3) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic wss_in_t make_sample(logic [7:0] dtype, logic signed [31:0] value,
                                          logic signed [31:0] stamp);
    wss_in_t s;
    s.data_type    = dtype;
    s.sample_value = value;
    s.collect_time = stamp;
    return s;
  endfunction

  // Mostly a few busy types so rings fill, wrap and report often
  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      case ($urandom_range(0, 2))
        0: return 8'd0;
        1: return 8'd37;
        default: return 8'(NUM_TYPES_DEF - 1);
      endcase
    end else if (r < 90) begin
      return 8'($urandom_range(0, NUM_TYPES_DEF - 1));
    end else begin
      return 8'($urandom_range(NUM_TYPES_DEF, 255));
    end
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom;
    end else if (r < 6) begin
      return int'($urandom_range(0, 2000)) - 1000;
    end else if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return S32_MAX;
        1: return S32_MIN;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end else if (r < 9) begin
      return S32_MAX - 32'($urandom_range(0, 1000));
    end else begin
      return S32_MIN + 32'($urandom_range(0, 1000));
    end
  endfunction

  // One input transaction, optionally preceded by an idle burst
  task automatic send_sample(wss_in_t smp, bit allow_idle);
    if (allow_idle && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    wss_in_t smp;
    int      total_sent;
    bit      tail;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, bad types, both ends of the type range
    send_sample(make_sample(8'd0, S32_MAX, S32_MIN), 1'b0);
    send_sample(make_sample(8'd0, S32_MIN, S32_MAX), 1'b1);
    send_sample(make_sample(8'(NUM_TYPES_DEF - 1), -32'sd1, 32'sd0), 1'b0);
    send_sample(make_sample(8'(NUM_TYPES_DEF - 1), 32'sd0, -32'sd1), 1'b1);
    send_sample(make_sample(8'(NUM_TYPES_DEF), S32_MAX, 32'sd1), 1'b0);
    send_sample(make_sample(8'd255, S32_MIN, -32'sd1), 1'b0);
    send_sample(make_sample(8'd128, -32'sd1, 32'sh5555_5555), 1'b1);
    send_sample(make_sample(8'd127, 32'sh5555_5555, 32'shAAAA_AAAA), 1'b0);
    send_sample(make_sample(8'd1, 32'shAAAA_AAAA, 32'sh5555_5555), 1'b0);
    send_sample(make_sample(8'd1, 32'sd1, S32_MAX), 1'b1);
    send_sample(make_sample(8'd2, -32'sd2, S32_MIN), 1'b0);
    send_sample(make_sample(8'd0, 32'sd0, 32'sd0), 1'b0);

    // Random: busy types dominate so windows close and rings wrap
    total_sent = 0;
    while (total_sent < RANDOM_SAMPLES) begin
      tail = (total_sent >= QUIET_FROM);
      quiet <= tail;
      smp.data_type    = pick_type();
      smp.sample_value = pick_value();
      smp.collect_time = $urandom;
      send_sample(smp, !tail && (total_sent / 120) % 4 != 3);
      total_sent++;
    end
    in_valid <= 1'b0;

    // Drain, then allow for one more report's worth of cycles
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (REPORT_LATENCY) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wss_pkg.sv
src/wss_ram.sv
src/wss_div.sv
src/windowed_sample_statistics.sv
src/wss_checker.sv
test/wss_checker.sv
test/testbench.sv
